// ===== hw/rtl/rau_pkg.sv =====
// Package for the rational arithmetic unit: widths and operation codes.
// No dependencies.
package rau_pkg;
	localparam int OpW  = 16;
	localparam int NumW = 48;
	localparam int DenW = 31;
	localparam int MagW = 2 * OpW;
	localparam int DivW = MagW + 1;

	typedef enum logic [1:0] {
		OP_ADD = 2'd0,
		OP_SUB = 2'd1,
		OP_MUL = 2'd2,
		OP_DIV = 2'd3
	} op_t;
endpackage

// ===== hw/rtl/rational_arithmetic_unit.sv =====
// Rational arithmetic unit top level: sequencer, one multiplier, shared divider.
// Depends on rau_pkg and rau_div.
//
// s_axis carries one operand transfer: op in tuser, a and b fractions in tdata.
// m_axis returns one transfer per operand: signed numerator, positive denominator,
// error flag in tuser. s_axis_tready is high only while the sequencer is idle and
// no result is waiting, so items run strictly one at a time.
// Every gcd step and every exact quotient uses the 33-bit restoring divider. Add/sub
// runs Euclid on the denominators, then on the result when sums are reduced;
// multiply/divide runs it on the product. Fewer than 25 Euclid steps are needed on
// the denominators and fewer than 48 on a sum or product.
// Zero denominators and division by zero give 0/1 with the error flag in the cycle
// after the transfer. The next item is accepted from the cycle after the result
// transfer. Multiplies use one 16x16 magnitude multiplier.
// Reset clears the sequencer and the result slot; reduce_sums resets to 0.
// A stalled receiver holds the result on m_axis; nothing new is accepted until
// it has been taken.
module rational_arithmetic_unit
	import rau_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic         cfg_wdata,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// tdata: a_num[15:0], a_den[31:16], b_num[47:32], b_den[63:48]
	input  logic [63:0]  s_axis_tdata,
	// tuser: req_type[1:0]
	input  logic [1:0]   s_axis_tuser,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// tdata: result_num[47:0], result_den[78:48], zero fill [79]
	output logic [79:0]  m_axis_tdata,
	// tuser: error_flag
	output logic         m_axis_tuser
);
	typedef enum logic [15:0] {
		S_IDLE = 16'h0001,
		S_GCD  = 16'h0002,
		S_GCDW = 16'h0004,
		S_QA   = 16'h0008,
		S_QAW  = 16'h0010,
		S_QB   = 16'h0020,
		S_QBW  = 16'h0040,
		S_T2   = 16'h0080,
		S_SUM  = 16'h0100,
		S_MUL  = 16'h0200,
		S_MUL2 = 16'h0400,
		S_DN   = 16'h0800,
		S_DNW  = 16'h1000,
		S_DD   = 16'h2000,
		S_DDW  = 16'h4000,
		S_OUT  = 16'h8000
	} st_t;

	st_t             st_q;
	op_t             op_q;
	logic            red_q, red_phase_q;
	logic            sa_q, sb_q, neg_q;
	logic [OpW-1:0]  an_q, ad_q, bn_q, bd_q, qa_q;
	logic [DivW-1:0] x_q, y_q, mag_q, den_q, l_q, g_q;
	logic            dstart;
	logic [DivW-1:0] ddd, dsr, quot, rem;
	logic            ddone;
	logic [MagW-1:0] prod;
	logic [OpW-1:0]  ma, mb;
	logic [OpW-1:0]  in_an, in_ad, in_bn, in_bd;
	logic            accept, in_err;
	logic [DivW-1:0] sum_mag;
	logic            sum_neg;
	logic            out_v_q;
	logic [NumW-1:0] rnum_q;
	logic [DenW-1:0] rden_q;
	logic            rerr_q;

	function automatic logic [OpW-1:0] absv(input logic [OpW-1:0] v);
		return v[OpW-1] ? (~v + 1'b1) : v;
	endfunction

	// operand fields, low OpW bits of each 16-bit slot
	assign in_an = s_axis_tdata[0 +: OpW];
	assign in_ad = s_axis_tdata[16 +: OpW];
	assign in_bn = s_axis_tdata[32 +: OpW];
	assign in_bd = s_axis_tdata[48 +: OpW];

	assign accept = s_axis_tvalid && s_axis_tready;
	assign in_err = (in_ad == '0) || (in_bd == '0) ||
	                (s_axis_tuser == OP_DIV && in_bn == '0);

	assign prod = MagW'(ma) * MagW'(mb);

	rau_div u_div (
		.clk(clk), .arst_n(arst_n), .start(dstart), .dividend(ddd), .divisor(dsr),
		.done(ddone), .quot(quot), .rem(rem)
	);

	assign s_axis_tready = (st_q == S_IDLE) && !out_v_q;
	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata  = {1'b0, rden_q, rnum_q};
	assign m_axis_tuser  = rerr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) red_q <= 1'b0;
		else if (cfg_we) red_q <= cfg_wdata;
	end

	// multiplier operand select
	always_comb begin
		ma = an_q;
		mb = bn_q;
		unique case (st_q)
			S_QAW:   begin ma = quot[OpW-1:0]; mb = bd_q; end
			S_QBW:   begin ma = an_q; mb = quot[OpW-1:0]; end
			S_T2:    begin ma = bn_q; mb = qa_q; end
			S_MUL:   begin ma = an_q; mb = (op_q == OP_DIV) ? bd_q : bn_q; end
			S_MUL2:  begin ma = ad_q; mb = (op_q == OP_DIV) ? bn_q : bd_q; end
			default: ;
		endcase
	end

	// divider start and operands; g_q is the divisor outside the Euclid loop
	always_comb begin
		dstart = 1'b0;
		ddd    = mag_q;
		dsr    = g_q;
		unique case (st_q)
			S_GCD:   begin dstart = (y_q != '0); ddd = x_q; dsr = y_q; end
			S_QA:    begin dstart = 1'b1; ddd = DivW'(ad_q); end
			S_QB:    begin dstart = 1'b1; ddd = DivW'(bd_q); end
			S_DN:    dstart = 1'b1;
			S_DD:    begin dstart = 1'b1; ddd = den_q; end
			default: ;
		endcase
	end

	// signed sum of the two scaled numerators (t1 in mag_q, t2 in den_q)
	always_comb begin
		priority if (sa_q == sb_q) begin
			sum_mag = mag_q + den_q; sum_neg = sa_q;
		end else if (mag_q >= den_q) begin
			sum_mag = mag_q - den_q; sum_neg = sa_q;
		end else begin
			sum_mag = den_q - mag_q; sum_neg = sb_q;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
		end else begin
			unique case (st_q)
				S_IDLE: if (accept && !in_err)
					st_q <= (s_axis_tuser == OP_MUL || s_axis_tuser == OP_DIV) ? S_MUL : S_GCD;
				S_GCD:  begin
					if (y_q == '0) st_q <= red_phase_q ? S_DN : S_QA;
					else st_q <= S_GCDW;
				end
				S_GCDW: if (ddone) st_q <= S_GCD;
				S_QA:   st_q <= S_QAW;
				S_QAW:  if (ddone) st_q <= S_QB;
				S_QB:   st_q <= S_QBW;
				S_QBW:  if (ddone) st_q <= S_T2;
				S_T2:   st_q <= S_SUM;
				S_SUM:  st_q <= red_q ? S_GCD : S_OUT;
				S_MUL:  st_q <= S_MUL2;
				S_MUL2: st_q <= S_GCD;
				S_DN:   st_q <= S_DNW;
				S_DNW:  if (ddone) st_q <= S_DD;
				S_DD:   st_q <= S_DDW;
				S_DDW:  if (ddone) st_q <= S_OUT;
				S_OUT:  st_q <= S_IDLE;
				default: st_q <= S_IDLE;
			endcase
		end
	end

	// result slot: loaded at S_OUT or by an error transfer, freed by m_axis
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
			rnum_q  <= '0;
			rden_q  <= DenW'(1);
			rerr_q  <= 1'b0;
		end else if (st_q == S_OUT) begin
			out_v_q <= 1'b1;
			rnum_q  <= neg_q ? (NumW'(0) - NumW'(mag_q)) : NumW'(mag_q);
			rden_q  <= DenW'(den_q);
			rerr_q  <= 1'b0;
		end else if (accept && in_err) begin
			out_v_q <= 1'b1;
			rnum_q  <= '0;
			rden_q  <= DenW'(1);
			rerr_q  <= 1'b1;
		end else if (m_axis_tvalid && m_axis_tready) begin
			out_v_q <= 1'b0;
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		unique case (st_q)
			S_IDLE: if (accept) begin
				op_q <= op_t'(s_axis_tuser);
				an_q <= absv(in_an);
				ad_q <= absv(in_ad);
				bn_q <= absv(in_bn);
				bd_q <= absv(in_bd);
				sa_q <= in_an[OpW-1] ^ in_ad[OpW-1];
				sb_q <= in_bn[OpW-1] ^ in_bd[OpW-1] ^ (s_axis_tuser == OP_SUB);
				x_q  <= DivW'(absv(in_ad));
				y_q  <= DivW'(absv(in_bd));
				red_phase_q <= 1'b0;
			end
			S_GCD:  if (y_q == '0) g_q <= x_q;
			S_GCDW: if (ddone) begin
				x_q <= y_q;
				y_q <= rem;
			end
			// lcm = (ad / g) * bd; ad / g also scales b
			S_QAW:  if (ddone) begin
				qa_q <= quot[OpW-1:0];
				l_q  <= DivW'(prod);
			end
			S_QBW:  if (ddone) mag_q <= DivW'(prod);
			S_T2:   den_q <= DivW'(prod);
			S_SUM:  begin
				mag_q <= sum_mag;
				neg_q <= sum_neg;
				den_q <= l_q;
				x_q   <= sum_mag;
				y_q   <= l_q;
				red_phase_q <= 1'b1;
			end
			S_MUL:  begin
				mag_q <= DivW'(prod);
				neg_q <= sa_q ^ sb_q;
			end
			S_MUL2: begin
				den_q <= DivW'(prod);
				x_q   <= mag_q;
				y_q   <= DivW'(prod);
				red_phase_q <= 1'b1;
			end
			S_DNW:  if (ddone) mag_q <= quot;
			S_DDW:  if (ddone) den_q <= quot;
			default: ;
		endcase
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser));
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready |-> !m_axis_tvalid);
	a_den_pos: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[78:48] != '0);
	a_err_val: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |->
			m_axis_tdata[47:0] == '0 && m_axis_tdata[78:48] == DenW'(1));
	a_state: assert property (@(posedge clk) disable iff (!arst_n) $onehot(st_q));
endmodule

// ===== hw/rtl/rau_div.sv =====
// Shared restoring divider: quotient and remainder, one bit per cycle.
// Depends on rau_pkg.
module rau_div
	import rau_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic [DivW-1:0] dividend,
	input  logic [DivW-1:0] divisor,
	output logic            done,
	output logic [DivW-1:0] quot,
	output logic [DivW-1:0] rem
);
	localparam int CntW = $clog2(DivW + 1);
	logic [CntW-1:0] cnt_q;
	logic            busy_q;
	logic [DivW-1:0] q_q, r_q, d_q;
	logic [DivW:0]   trial;

	assign trial = {r_q, q_q[DivW-1]} - {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CntW'(DivW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CntW'(1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q <= dividend;
			r_q <= '0;
			d_q <= divisor;
		end else if (busy_q) begin
			if (!trial[DivW]) begin
				r_q <= trial[DivW-1:0];
				q_q <= {q_q[DivW-2:0], 1'b1};
			end else begin
				r_q <= {r_q[DivW-2:0], q_q[DivW-1]};
				q_q <= {q_q[DivW-2:0], 1'b0};
			end
		end
	end

	assign quot = q_q;
	assign rem  = r_q;
endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for rational_arithmetic_unit: directed table, then random fractions.
// Depends on rau_pkg and the unit RTL; predictor computes the expected fraction in-line.
`timescale 1ns / 1ps

module testbench
	import rau_pkg::*;
();

	localparam int WatchLimit = 60000;

	typedef struct packed {
		logic [47:0] num;
		logic [30:0] den;
		logic        err;
	} frac_res_t;

	typedef struct {
		op_t         op;
		logic [15:0] an, ad, bn, bd;
		logic        known;
		frac_res_t   res;
	} vec_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic        cfg_wdata = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [63:0] s_axis_tdata = '0;
	logic [1:0]  s_axis_tuser = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [79:0] m_axis_tdata;
	logic        m_axis_tuser;

	frac_res_t   pending_q[$];
	logic        reduce_sums_mdl = 1'b0;
	int          errors = 0;
	int          results_seen = 0;
	int          idle_cycles = 0;
	int          src_gap = 0;
	int          snk_stall = 0;

	always #10 clk = ~clk;

	rational_arithmetic_unit u_top (.*);

	function automatic logic [63:0] gcd64(logic [63:0] x, logic [63:0] y);
		logic [63:0] t;
		while (y != 0) begin
			t = x % y;
			x = y;
			y = t;
		end
		return x;
	endfunction

	// Magnitude of a 16-bit two's complement field; 0x8000 gives 32768.
	function automatic logic [63:0] mag16(logic [15:0] v);
		logic [15:0] m;
		m = v[15] ? (~v + 16'd1) : v;
		return {48'd0, m};
	endfunction

	// Expected fraction for one operand transfer, at the current reduce_sums.
	function automatic frac_res_t predict_frac(op_t op, logic [15:0] an_r, logic [15:0] ad_r,
			logic [15:0] bn_r, logic [15:0] bd_r);
		logic [63:0] an, ad, bn, bd, mag, den, g, l, t1, t2;
		logic        sa, sb, neg;
		frac_res_t   r;
		an = mag16(an_r);
		ad = mag16(ad_r);
		bn = mag16(bn_r);
		bd = mag16(bd_r);
		sa = an_r[15] ^ ad_r[15];
		sb = bn_r[15] ^ bd_r[15];
		r = '{num: '0, den: 31'd1, err: 1'b1};
		if (ad == 0 || bd == 0) return r;
		if (op == OP_ADD || op == OP_SUB) begin
			if (op == OP_SUB) sb = ~sb;
			g = gcd64(ad, bd);
			l = (ad / g) * bd;
			t1 = an * (l / ad);
			t2 = bn * (l / bd);
			if (sa == sb) begin
				mag = t1 + t2; neg = sa;
			end else if (t1 >= t2) begin
				mag = t1 - t2; neg = sa;
			end else begin
				mag = t2 - t1; neg = sb;
			end
			den = l;
			if (reduce_sums_mdl) begin
				g = gcd64(mag, den);
				mag = mag / g;
				den = den / g;
			end
		end else begin
			neg = sa ^ sb;
			if (op == OP_MUL) begin
				mag = an * bn; den = ad * bd;
			end else begin
				if (bn == 0) return r;
				mag = an * bd; den = ad * bn;
			end
			g = gcd64(mag, den);
			mag = mag / g;
			den = den / g;
		end
		if (mag == 0) neg = 1'b0;
		if (den == 0 || den > 64'h7fff_ffff) return r;
		if (neg ? (mag > 64'h8000_0000_0000) : (mag >= 64'h8000_0000_0000)) return r;
		r.num = neg ? 48'(-mag) : 48'(mag);
		r.den = 31'(den);
		r.err = 1'b0;
		return r;
	endfunction

	// Result checker and idle watchdog on the rising edge; the receiver stall is driven on the falling edge.
	always @(posedge clk) begin
		frac_res_t exp_r;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			results_seen++;
			if (pending_q.size() == 0) begin
				$display("%0t result with no transfer outstanding: %h", $time, m_axis_tdata);
				errors++;
			end else begin
				exp_r = pending_q.pop_front();
				if (m_axis_tdata[47:0] !== exp_r.num || m_axis_tdata[78:48] !== exp_r.den ||
						m_axis_tuser !== exp_r.err) begin
					$display("%0t mismatch: expected %0d/%0d err %b, actual %0d/%0d err %b",
						$time, $signed(exp_r.num), exp_r.den, exp_r.err,
						$signed(m_axis_tdata[47:0]), m_axis_tdata[78:48], m_axis_tuser);
					errors++;
				end
			end
		end
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > WatchLimit) begin
			$display("%0t watchdog expired", $time);
			$display("testbench: errors");
			$finish;
		end
	end

	always @(negedge clk)
		m_axis_tready <= ($urandom_range(99) >= snk_stall);

	// One operand transfer; the expectation is queued when it is accepted.
	// tvalid drops only in source gaps and in drain, so it is driven once per edge.
	task automatic send_item(op_t op, logic [15:0] an, logic [15:0] ad, logic [15:0] bn,
			logic [15:0] bd, logic known, frac_res_t res);
		frac_res_t pred;
		while ($urandom_range(99) < src_gap) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= op;
		s_axis_tdata  <= {bd, bn, ad, an};
		pred = predict_frac(op, an, ad, bn, bd);
		if (known && pred !== res) begin
			$display("%0t table row disagrees with predictor: %h vs %h", $time, res, pred);
			errors++;
		end
		do @(posedge clk); while (!s_axis_tready);
		pending_q.push_back(pred);
		@(negedge clk);
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (pending_q.size() != 0) @(negedge clk);
		repeat (40) @(negedge clk);
	endtask

	task automatic set_reduce(logic v);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		reduce_sums_mdl = v;
	endtask

	// Random operand: small values half the time so the Euclid runs stay short, else extremes, zero or any value.
	function automatic logic [15:0] rnd_val();
		case ($urandom_range(9))
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return 16'd0;
			3, 4: return 16'($urandom);
			default: return 16'($signed($urandom_range(40)) - 20);
		endcase
	endfunction

	vec_t table_rows[$];
	frac_res_t unk = '0;

	initial begin
		op_t op;
		table_rows = '{
			'{OP_ADD, 16'd1, 16'd2, 16'd1, 16'd3, 1, '{48'd5, 31'd6, 1'b0}},
			'{OP_SUB, 16'd1, 16'd2, 16'd1, 16'd2, 1, '{48'd0, 31'd2, 1'b0}},
			'{OP_MUL, 16'd2, 16'd3, 16'd3, 16'd4, 1, '{48'd1, 31'd2, 1'b0}},
			'{OP_DIV, 16'd1, 16'd2, 16'd1, 16'd4, 1, '{48'd2, 31'd1, 1'b0}},
			'{OP_ADD, 16'd1, 16'd0, 16'd1, 16'd1, 1, '{48'd0, 31'd1, 1'b1}},
			'{OP_MUL, 16'd1, 16'd1, 16'd1, 16'd0, 1, '{48'd0, 31'd1, 1'b1}},
			'{OP_DIV, 16'd5, 16'd7, 16'd0, 16'd3, 1, '{48'd0, 31'd1, 1'b1}},
			'{OP_MUL, 16'h8000, 16'd1, 16'h8000, 16'd1, 1, '{48'h4000_0000, 31'd1, 1'b0}},
			'{OP_MUL, 16'd1, 16'h8000, 16'd1, 16'h8000, 1, '{48'd1, 31'h4000_0000, 1'b0}},
			'{OP_DIV, 16'd3, 16'hfffd, 16'd1, 16'd1, 1, '{48'hffff_ffff_ffff, 31'd1, 1'b0}},
			'{OP_ADD, 16'h7fff, 16'h7fff, 16'h8000, 16'h8000, 0, unk},
			'{OP_SUB, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000, 0, unk},
			'{OP_ADD, 16'hffff, 16'd3, 16'd1, 16'hfffd, 0, unk},
			'{OP_DIV, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 1, '{48'd1, 31'd1, 1'b0}},
			'{OP_MUL, 16'd0, 16'hffff, 16'd5, 16'd9, 1, '{48'd0, 31'd1, 1'b0}},
			'{OP_SUB, 16'h5555, 16'h7ff9, 16'haaaa, 16'h6001, 0, unk}
		};
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		// Directed rows at reset setting, then two more rows and the add/sub rows again with sums reduced.
		foreach (table_rows[i])
			send_item(table_rows[i].op, table_rows[i].an, table_rows[i].ad,
				table_rows[i].bn, table_rows[i].bd, table_rows[i].known, table_rows[i].res);
		drain();
		set_reduce(1'b1);
		send_item(OP_SUB, 16'd1, 16'd2, 16'd1, 16'd2, 1, '{48'd0, 31'd1, 1'b0});
		send_item(OP_ADD, 16'd1, 16'd6, 16'd1, 16'd3, 1, '{48'd1, 31'd2, 1'b0});
		foreach (table_rows[i])
			if (table_rows[i].op inside {OP_ADD, OP_SUB})
				send_item(table_rows[i].op, table_rows[i].an, table_rows[i].ad,
					table_rows[i].bn, table_rows[i].bd, 0, unk);
		// Random phases: three idling profiles, reduce_sums toggled within each.
		for (int ph = 0; ph < 6; ph++) begin
			drain();
			set_reduce(ph[0]);
			src_gap   = (ph < 2) ? 26 : (ph < 4) ? 50 : 0;
			snk_stall = (ph < 2) ? 50 : (ph < 4) ? 26 : 0;
			repeat (270) begin
				op = op_t'($urandom_range(3));
				send_item(op, rnd_val(), rnd_val(), rnd_val(), rnd_val(), 0, unk);
			end
		end
		drain();
		$display("covered %0d results over all four ops, both reduce_sums values,", results_seen);
		$display("zero denominators, division by zero and operand extremes");
		if (errors == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end
endmodule
